>>> src/assert_macros.svh
// Assertion helpers, sampled on the block clock and off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SLI_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SLI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/sli_pkg.sv
package sli_pkg;

   localparam int SLI_CAPACITY = 16;
   localparam int DATA_W       = 32;
   localparam int OCC_W        = 5;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_DUMP   = 2'd2;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_FULL     = 2'd1;
   localparam logic [1:0] STAT_NOTFOUND = 2'd2;
   localparam logic [1:0] STAT_EMPTY    = 2'd3;

   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_INSERT = 2'd1;
   localparam logic [1:0] CELL_DELETE = 2'd2;
   localparam logic [1:0] CELL_ROTATE = 2'd3;

   typedef struct packed {
      logic [1:0]               op;
      logic signed [DATA_W-1:0] value;
   } cell_ctl_type;

endpackage

>>> src/sli_cell.sv
module sli_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  logic                          clock,
   input  sli_pkg::cell_ctl_type         ctl,
   input  logic [CNT_W-1:0]              count,
   input  logic signed [sli_pkg::DATA_W-1:0] left_entry,
   input  logic                          left_less,
   input  logic signed [sli_pkg::DATA_W-1:0] right_entry,
   input  logic signed [sli_pkg::DATA_W-1:0] head_entry,
   output logic signed [sli_pkg::DATA_W-1:0] entry,
   output logic                          less,
   output logic                          eq
);
   import sli_pkg::*;

   localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

   logic signed [DATA_W-1:0] entry_ff;
   logic signed [DATA_W-1:0] entry_in;
   logic                     occupied;
   logic                     is_tail;

   assign occupied = (IDX < count);
   assign is_tail  = (IDX == (count - CNT_W'(1)));
   assign less     = occupied && (entry_ff < ctl.value);
   assign eq       = occupied && (entry_ff == ctl.value);
   assign entry    = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      unique case (ctl.op)
         CELL_HOLD: begin
            entry_in = entry_ff;
         end
         CELL_INSERT: begin
            if (!less) begin
               entry_in = left_less ? ctl.value : left_entry;
            end
         end
         CELL_DELETE: begin
            if (!less) begin
               entry_in = right_entry;
            end
         end
         CELL_ROTATE: begin
            if (occupied) begin
               entry_in = is_tail ? head_entry : right_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

>>> src/sorted_list_insert_delete_top.sv
// Channel | Dir | Handshake             | Payload
// req_    | in  | req_tvalid/req_tready | tdata: command, value
// rsp_    | out | rsp_tvalid/rsp_tready | tdata: element, occupancy; tuser: status; tlast
//
// Insert, delete and unused commands register the request; then every cell compares
// against the value and, if an insert or delete succeeds, the chain shifts by one.
// A dump of N entries rotates the chain one entry per cycle, while the result is
// not stalled, into the result register; it is back in order after the last one.
// Reset (synchronous) empties the store; no clearing pass is needed.
// A stalled result holds the block; a new request is taken while it waits.
`include "assert_macros.svh"

module sorted_list_insert_delete_top #(
   parameter int CAPACITY = sli_pkg::SLI_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [1:0] command, [33:2] value, [39:34] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] element, [36:32] occupancy, [39:37] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast
);
   import sli_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_DUMP = 2'd2;

   logic [1:0]               state_ff, state_in;
   logic [1:0]               cmd_ff, cmd_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         dump_idx_ff, dump_idx_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] rsp_element_ff, rsp_element_in;
   logic [OCC_W-1:0]         rsp_occ_ff, rsp_occ_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     rsp_load;

   cell_ctl_type             ctl;
   logic signed [DATA_W-1:0] entry_w [CAPACITY];
   logic [CAPACITY-1:0]      less_w;
   logic [CAPACITY-1:0]      eq_w;
   logic                     found;
   logic                     slot_free;
   logic                     req_fire;

   assign found      = |eq_w;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic signed [DATA_W-1:0] left_e;
         logic signed [DATA_W-1:0] right_e;
         logic                     left_l;
         if (gi == 0) begin : g_head
            assign left_e = value_ff;
            assign left_l = 1'b1;
         end else begin : g_body
            assign left_e = entry_w[gi-1];
            assign left_l = less_w[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_end
            assign right_e = entry_w[gi];
         end else begin : g_mid
            assign right_e = entry_w[gi+1];
         end
         sli_cell #(
            .INDEX (gi),
            .CNT_W (CNT_W)
         ) u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .count       (count_ff),
            .left_entry  (left_e),
            .left_less   (left_l),
            .right_entry (right_e),
            .head_entry  (entry_w[0]),
            .entry       (entry_w[gi]),
            .less        (less_w[gi]),
            .eq          (eq_w[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      value_in       = value_ff;
      count_in       = count_ff;
      dump_idx_in    = dump_idx_ff;
      ctl.op         = CELL_HOLD;
      ctl.value      = value_ff;
      rsp_load       = 1'b0;
      rsp_status_in  = STAT_OK;
      rsp_element_in = '0;
      rsp_last_in    = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in   = req_tdata[1:0];
               value_in = req_tdata[33:2];
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (slot_free) begin
               state_in = S_IDLE;
               rsp_load = 1'b1;
               priority if (cmd_ff == CMD_INSERT) begin
                  if (count_ff == CNT_W'(CAPACITY)) begin
                     rsp_status_in = STAT_FULL;
                  end else begin
                     ctl.op   = CELL_INSERT;
                     count_in = count_ff + CNT_W'(1);
                  end
               end else if (cmd_ff == CMD_DELETE) begin
                  if (found) begin
                     ctl.op   = CELL_DELETE;
                     count_in = count_ff - CNT_W'(1);
                  end else begin
                     rsp_status_in = STAT_NOTFOUND;
                  end
               end else if (cmd_ff == CMD_DUMP) begin
                  if (count_ff == '0) begin
                     rsp_status_in = STAT_EMPTY;
                  end else begin
                     rsp_load    = 1'b0;
                     dump_idx_in = '0;
                     state_in    = S_DUMP;
                  end
               end else begin
                  rsp_status_in = STAT_OK;
               end
            end
         end
         S_DUMP: begin
            if (slot_free) begin
               rsp_load       = 1'b1;
               rsp_element_in = entry_w[0];
               rsp_last_in    = (dump_idx_ff == (count_ff - CNT_W'(1)));
               ctl.op         = CELL_ROTATE;
               dump_idx_in    = dump_idx_ff + CNT_W'(1);
               if (rsp_last_in) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_occ_in   = OCC_W'(count_in);
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_idx_ff  <= dump_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      value_ff <= value_in;
      if (rsp_load) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_element_ff <= rsp_element_in;
         rsp_occ_ff     <= rsp_occ_in;
         rsp_last_ff    <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_occ_ff, rsp_element_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   `SLI_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(CAPACITY), "count over capacity")
   `SLI_ASSERT_NOW(a_dump_idx, state_ff == S_DUMP, dump_idx_ff < count_ff, "dump index past count")
   `SLI_ASSERT_NEXT(a_req_exec, req_fire, state_ff == S_EXEC, "request not executed next")
   `SLI_ASSERT_NEXT(a_count_hold, state_ff != S_EXEC, $stable(count_ff), "count moved outside exec")

endmodule

>>> sim/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import sli_pkg::*;

   localparam int          CAP        = SLI_CAPACITY;
   localparam logic [1:0]  CMD_UNUSED = 2'd3;
   localparam int          QUIET_TAIL = 25;
   localparam int          IDLE_LIMIT = 2000;
   localparam int          DRAIN_WAIT = 20;

   typedef struct {
      logic [1:0]               command;
      logic signed [DATA_W-1:0] value;
      bit                       hold;
   } list_req_type;

   typedef struct {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] element;
      logic [OCC_W-1:0]         occupancy;
      logic                     last;
   } list_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   list_req_type req_backlog[$];
   list_rsp_type results_due[$];
   list_req_type req_shown;

   logic signed [DATA_W-1:0] sorted_vals[CAP];
   int                       stored_count = 0;

   int  req_gap = 0;
   int  rsp_gap = 0;
   int  idle_cycles = 0;
   int  fault_count = 0;
   logic next_valid;

   sorted_list_insert_delete_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   task automatic push_result(input logic [1:0] status, input logic signed [DATA_W-1:0] element,
                              input logic last);
      list_rsp_type r;
      r.status    = status;
      r.element   = element;
      r.occupancy = OCC_W'(stored_count);
      r.last      = last;
      results_due.push_back(r);
   endtask

   // Sorted store update for one accepted request, queuing the results it produces.
   task automatic apply_list_op(input list_req_type rq);
      int pos;
      int i;
      pos = 0;
      case (rq.command)
         CMD_INSERT: begin
            if (stored_count >= CAP) begin
               push_result(STAT_FULL, '0, 1'b1);
            end else begin
               while (pos < stored_count && sorted_vals[pos] < rq.value) pos++;
               for (i = stored_count; i > pos; i--) sorted_vals[i] = sorted_vals[i-1];
               sorted_vals[pos] = rq.value;
               stored_count++;
               push_result(STAT_OK, '0, 1'b1);
            end
         end
         CMD_DELETE: begin
            while (pos < stored_count && sorted_vals[pos] != rq.value) pos++;
            if (pos >= stored_count) begin
               push_result(STAT_NOTFOUND, '0, 1'b1);
            end else begin
               for (i = pos; i + 1 < stored_count; i++) sorted_vals[i] = sorted_vals[i+1];
               stored_count--;
               push_result(STAT_OK, '0, 1'b1);
            end
         end
         CMD_DUMP: begin
            if (stored_count == 0) begin
               push_result(STAT_EMPTY, '0, 1'b1);
            end else begin
               for (i = 0; i < stored_count; i++)
                  push_result(STAT_OK, sorted_vals[i], logic'(i + 1 == stored_count));
            end
         end
         default: begin
            push_result(STAT_OK, '0, 1'b1);
         end
      endcase
   endtask

   task automatic queue_req(input logic [1:0] command, input logic signed [DATA_W-1:0] value,
                            input bit hold = 1'b0);
      list_req_type rq;
      rq.command = command;
      rq.value   = value;
      rq.hold    = hold;
      req_backlog.push_back(rq);
   endtask

   task automatic report_mismatch(input string field, input logic [DATA_W-1:0] exp_val,
                                  input logic [DATA_W-1:0] act_val);
      fault_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_val, act_val);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready) apply_list_op(req_shown);
         if (!req_tvalid || req_tready) begin
            next_valid = 1'b0;
            if (req_gap > 0) begin
               req_gap--;
            end else if (req_backlog.size() > 0) begin
               if (req_backlog.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
                  req_gap = $urandom_range(0, 7);
               end else if (!req_backlog[0].hold || results_due.size() == 0) begin
                  req_shown  = req_backlog.pop_front();
                  next_valid = 1'b1;
                  req_tdata <= {6'b0, req_shown.value, req_shown.command};
               end
            end
            req_tvalid <= next_valid;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      list_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (results_due.size() == 0) begin
               fault_count++;
               $display("%0t: unexpected result, expected none, actual status %0d element %0h",
                        $time, rsp_tuser, rsp_tdata[31:0]);
            end else begin
               want = results_due.pop_front();
               if (rsp_tuser !== want.status)
                  report_mismatch("status", DATA_W'(want.status), DATA_W'(rsp_tuser));
               if (rsp_tdata[31:0] !== want.element)
                  report_mismatch("element", want.element, rsp_tdata[31:0]);
               if (rsp_tdata[36:32] !== want.occupancy)
                  report_mismatch("occupancy", DATA_W'(want.occupancy), DATA_W'(rsp_tdata[36:32]));
               if (rsp_tlast !== want.last)
                  report_mismatch("last", DATA_W'(want.last), DATA_W'(rsp_tlast));
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else if (req_backlog.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
            rsp_gap = $urandom_range(0, 7);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      logic signed [DATA_W-1:0] pool[12];
      logic signed [DATA_W-1:0] v;
      logic [1:0]               cmd;
      int                       pick;
      int                       phase;
      int                       n;

      // empty store cases
      queue_req(CMD_DUMP, 32'sh1234_5678);
      queue_req(CMD_DELETE, 32'sh0);
      queue_req(CMD_UNUSED, 32'shFFFF_FFFF);
      // fill to capacity with extremes and duplicates
      queue_req(CMD_INSERT, 32'sh7FFF_FFFF);
      queue_req(CMD_INSERT, 32'sh8000_0000);
      queue_req(CMD_INSERT, 32'sh0);
      queue_req(CMD_INSERT, -32'sd1);
      queue_req(CMD_INSERT, 32'sd1);
      queue_req(CMD_INSERT, 32'sh0);
      queue_req(CMD_INSERT, 32'sh5555_5555);
      queue_req(CMD_INSERT, 32'shAAAA_AAAA);
      queue_req(CMD_INSERT, -32'sd5);
      queue_req(CMD_INSERT, 32'sd100);
      queue_req(CMD_INSERT, 32'sd100);
      queue_req(CMD_INSERT, -32'sd100);
      queue_req(CMD_INSERT, 32'sd7);
      queue_req(CMD_INSERT, 32'sh8000_0000);
      queue_req(CMD_INSERT, 32'sd9);
      queue_req(CMD_INSERT, 32'sd42);
      // full store
      queue_req(CMD_INSERT, 32'sd3);
      queue_req(CMD_DUMP, 32'sh0);
      queue_req(CMD_UNUSED, 32'sh0);
      queue_req(CMD_DELETE, 32'sd12345);
      queue_req(CMD_DELETE, 32'sd100);
      queue_req(CMD_DELETE, 32'sh8000_0000);
      queue_req(CMD_DUMP, 32'shFFFF_FFFF, 1'b1);

      pool[0] = 32'sh7FFF_FFFF;
      pool[1] = 32'sh8000_0000;
      pool[2] = 32'sh0;
      pool[3] = -32'sd1;
      for (int i = 4; i < 12; i++)
         pool[i] = (i < 8) ? $signed($urandom_range(0, 20)) - 10 : $signed($urandom);

      // alternating insert-heavy and delete-heavy phases to sweep full and empty
      for (int k = 0; k < 200; k++) begin
         phase = k / 40;
         pick  = $urandom_range(0, 99);
         if (phase % 2 == 0)
            cmd = (pick < 60) ? CMD_INSERT : (pick < 85) ? CMD_DELETE :
                  (pick < 95) ? CMD_DUMP : CMD_UNUSED;
         else
            cmd = (pick < 60) ? CMD_DELETE : (pick < 82) ? CMD_INSERT :
                  (pick < 95) ? CMD_DUMP : CMD_UNUSED;
         n = $urandom_range(0, 9);
         v = (n < 7) ? pool[$urandom_range(0, 11)] : $signed($urandom);
         queue_req(cmd, v, (k == 0 || k == 100 || k == 150));
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      wait (req_backlog.size() == 0);
      @(posedge clock);
      wait (!req_tvalid);
      wait (results_due.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (results_due.size() != 0) begin
         fault_count++;
         $display("%0t: %0d results expected, none arrived", $time, results_due.size());
      end
      if (fault_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+src
src/sli_pkg.sv
src/sli_cell.sv
src/sorted_list_insert_delete_top.sv
sim/testbench.sv
